### src/ovsd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ovsd_pkg
// Shared types, constants and the per-length offset table for the decoder.
// ============================================================================
package ovsd_pkg;

    localparam int MAX_BYTES_DEFAULT = 10;
    localparam int VALUE_W           = 64;
    localparam int LENGTH_W          = 4;
    localparam int STATUS_W          = 2;
    localparam int BYTE_W            = 8;
    localparam int GROUP_W           = 7;
    localparam int OUT_TDATA_W       = 72;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_INCOMPLETE = 2'd1,
        STATUS_TOO_LONG   = 2'd2
    } status_t;

    typedef struct packed {
        logic                emit;
        logic [VALUE_W-1:0]  value;
        logic [LENGTH_W-1:0] length;
        status_t             status;
    } ovsd_result_t;

    // The smallest value that needs n bytes; adding it makes the code bijective.
    function automatic logic [VALUE_W-1:0] min_for_len(input logic [LENGTH_W-1:0] n);
        logic [VALUE_W-1:0] m;
        begin
            case (n)
                4'd2:    m = 64'h0000000000000080;
                4'd3:    m = 64'h0000000000004080;
                4'd4:    m = 64'h0000000000204080;
                4'd5:    m = 64'h0000000010204080;
                4'd6:    m = 64'h0000000810204080;
                4'd7:    m = 64'h0000040810204080;
                4'd8:    m = 64'h0002040810204080;
                4'd9:    m = 64'h0102040810204080;
                4'd10:   m = 64'h8102040810204080;
                default: m = '0;
            endcase
            return m;
        end
    endfunction

endpackage

### src/offset_varint_stream_decoder_top.sv
`timescale 1ns / 1ps
// ============================================================================
// offset_varint_stream_decoder_top
// Bijective base-128 big-endian varint decoder, one byte per beat.
// ============================================================================
//  Channel   Dir  Beat contents
//  s_axis    in   tdata[7:0] data_byte, tlast buffer_end
//  m_axis    out  tdata[63:0] value, [67:64] length; tuser[1:0] status
//
//  A byte is decoded combinationally while it sits in the input register, and the
//  result beat for the byte that ends its number is registered when that byte advances.
//  A new byte is taken every cycle while results drain.
//  Reset clears the accumulator, the byte count and both valid flags.
//  A stalled result holds the byte that produced it in the input register;
//  bytes that end no number keep flowing during a stall.
module offset_varint_stream_decoder_top #(
    parameter int MAX_BYTES = ovsd_pkg::MAX_BYTES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ovsd_pkg::BYTE_W-1:0]      s_axis_tdata,  // data_byte
    input  logic                             s_axis_tlast,  // buffer_end
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ovsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // value, length, zero pad
    output logic [ovsd_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);
    import ovsd_pkg::*;

    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_end_reg;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;
    logic [LENGTH_W-1:0] count_reg;
    logic [LENGTH_W-1:0] count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [LENGTH_W-1:0] out_length_reg;
    status_t             out_status_reg;
    ovsd_result_t        res;
    logic                out_free;
    logic                advance;
    logic                in_take;

    ovsd_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .data_byte  (in_byte_reg),
        .buffer_end (in_end_reg),
        .acc        (acc_reg),
        .count      (count_reg),
        .result     (res),
        .acc_next   (acc_next),
        .count_next (count_next)
    );

    assign out_free       = !out_valid_reg || m_axis_tready;
    assign advance        = in_valid_reg && (!res.emit || out_free);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_take        = s_axis_tvalid && s_axis_tready;
    assign out_valid_next = (out_valid_reg && !m_axis_tready) || (advance && res.emit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                acc_reg   <= acc_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
        if (advance && res.emit)
        begin
            out_value_reg  <= res.value;
            out_length_reg <= res.length;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-VALUE_W-LENGTH_W){1'b0}}, out_length_reg, out_value_reg};
    assign m_axis_tuser  = out_status_reg;

endmodule

### src/ovsd_core.sv
`timescale 1ns / 1ps
// ============================================================================
// ovsd_core
// Decodes one byte against the running accumulator and byte count.
// ============================================================================
module ovsd_core #(
    parameter int MAX_BYTES = ovsd_pkg::MAX_BYTES_DEFAULT
) (
    input  logic [ovsd_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          buffer_end,
    input  logic [ovsd_pkg::VALUE_W-1:0]  acc,
    input  logic [ovsd_pkg::LENGTH_W-1:0] count,
    output ovsd_pkg::ovsd_result_t        result,
    output logic [ovsd_pkg::VALUE_W-1:0]  acc_next,
    output logic [ovsd_pkg::LENGTH_W-1:0] count_next
);
    import ovsd_pkg::*;

    logic [VALUE_W-1:0]  acc_shift;
    logic [LENGTH_W-1:0] cnt;

    assign acc_shift = {acc[VALUE_W-GROUP_W-1:0], data_byte[GROUP_W-1:0]};
    assign cnt       = count + LENGTH_W'(1);

    always_comb
    begin
        result.emit   = 1'b0;
        result.value  = '0;
        result.length = cnt;
        result.status = STATUS_OK;
        if (!data_byte[BYTE_W-1])
        begin
            result.emit  = 1'b1;
            result.value = acc_shift + min_for_len(cnt);
        end
        else if (cnt >= LENGTH_W'(MAX_BYTES))
        begin
            result.emit   = 1'b1;
            result.status = STATUS_TOO_LONG;
        end
        else if (buffer_end)
        begin
            result.emit   = 1'b1;
            result.status = STATUS_INCOMPLETE;
        end
    end

    assign acc_next   = result.emit ? '0 : acc_shift;
    assign count_next = result.emit ? '0 : cnt;

endmodule
